### rtl/pdcm_pkg.sv
package pdcm_pkg;

  // Fixed field widths
  localparam int TS_W        = 24;
  localparam int PERIOD_W    = 24;
  localparam int DUTY_W      = 8;
  localparam int NARROW_BITS = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 2;
  localparam int LIMIT_W     = 2;

  // Duty quotient is produced one bit per divider step
  localparam int DIV_STEPS   = DUTY_W;
  localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_TIMESTAMPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LIMIT  = 2'd2;

  // Input operation codes
  localparam logic OP_CAPTURE  = 1'b0;
  localparam logic OP_OVERFLOW = 1'b1;

  // Measurement phase
  typedef enum logic [1:0] {
    PH_START,
    PH_PERIOD,
    PH_FALL
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PUSH
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emits;
    logic needs_div;
    logic out_free;
  } status_t;

endpackage

### rtl/pdcm_ctrl.sv
module pdcm_ctrl
  import pdcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic [STEP_CNT_W-1:0] step_cnt, step_cnt_next;
  logic accept;

  assign accept = in_valid && in_ready;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = accept;
        step_cnt_next = '0;
        if (accept && st.emits) begin
          state_next = st.needs_div ? ST_DIVIDE : ST_PUSH;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push = st.out_free;
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A result with no division goes straight to the output stage
  a_direct_push: assert property (@(posedge clk) disable iff (rst)
    accept && st.emits && !st.needs_div |=> state == ST_PUSH)
    else $error("direct result did not go to push");

  // Division always starts from a cleared step count
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_DIVIDE) |-> step_cnt == '0)
    else $error("divide entered with stale step count");

  // The output stage is never overwritten while it still holds a word
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> st.out_free)
    else $error("push into a full output stage");

endmodule

### rtl/pdcm_datapath.sv
module pdcm_datapath
  import pdcm_pkg::*;
#(
  parameter int TIMESTAMP_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  operation,
  input  logic                  edge_falling,
  input  logic [TS_W-1:0]       timestamp,
  input  cmd_t                  cmd,
  output status_t               st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PERIOD_W-1:0]   period_ticks,
  output logic [DUTY_W-1:0]     duty_fraction,
  output logic                  timed_out
);

  localparam int TW = TIMESTAMP_BITS;
  localparam logic [TW-1:0] NARROW_MASK = TW'({NARROW_BITS{1'b1}});

  // Configuration
  logic               duty_enable;
  logic               wide_timestamps;
  logic [LIMIT_W-1:0] overflow_limit;

  // Measurement state
  phase_t             phase;
  logic [TW-1:0]      start_time;
  logic [TW-1:0]      period_end_time;
  logic [LIMIT_W-1:0] overflow_count;

  // Pending result and divider
  logic [TW-1:0]      pend_period;
  logic [TW-1:0]      rem;
  logic [DUTY_W-1:0]  duty_q;
  logic               pend_timeout;

  logic [TW-1:0]      ts_w, end_sel, mask, period_m, on_m;
  logic [LIMIT_W:0]   cnt_inc;
  logic               tick_abort;
  logic [DUTY_W-1:0]  duty_now;
  logic [TW:0]        rem_sh, div_ext;
  logic               q_bit;
  logic [TW-1:0]      rem_next;

  // Differences for the item on the input
  always_comb begin
    ts_w     = TW'(timestamp);
    end_sel  = (phase == PH_PERIOD) ? ts_w : period_end_time;
    mask     = wide_timestamps ? '1 : NARROW_MASK;
    period_m = (end_sel - start_time) & mask;
    on_m     = (ts_w - end_sel) & mask;
    cnt_inc  = {1'b0, overflow_count} + 1'b1;
    tick_abort = cnt_inc > {1'b0, overflow_limit};
    duty_now = (duty_enable && period_m != '0 && on_m >= period_m) ? '1 : '0;
  end

  // Status for the controller
  always_comb begin
    if (operation == OP_OVERFLOW) begin
      st.emits = tick_abort;
    end else begin
      st.emits = (phase == PH_PERIOD && !edge_falling && !duty_enable) ||
                 (phase == PH_FALL && edge_falling);
    end
    st.needs_div = st.emits && operation == OP_CAPTURE && duty_enable &&
                   period_m != '0 && on_m < period_m;
    st.out_free  = !out_valid || out_ready;
  end

  // One restoring step: on-time stays below the period, so 8 bits suffice
  always_comb begin
    rem_sh   = {rem, 1'b0};
    div_ext  = {1'b0, pend_period};
    q_bit    = rem_sh >= div_ext;
    rem_next = q_bit ? TW'(rem_sh - div_ext) : rem_sh[TW-1:0];
  end

  // Configuration and measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_enable     <= 1'b1;
      wide_timestamps <= 1'b1;
      overflow_limit  <= LIMIT_W'(1);
      phase           <= PH_START;
      start_time      <= '0;
      period_end_time <= '0;
      overflow_count  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DUTY_ENABLE:     duty_enable     <= cfg_data[0];
          CFG_WIDE_TIMESTAMPS: wide_timestamps <= cfg_data[0];
          CFG_OVERFLOW_LIMIT:  overflow_limit  <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (operation == OP_OVERFLOW) begin
          if (tick_abort) begin
            phase          <= PH_START;
            overflow_count <= '0;
          end else begin
            overflow_count <= cnt_inc[LIMIT_W-1:0];
          end
        end else begin
          unique case (phase)
            PH_PERIOD: begin
              if (!edge_falling) begin
                period_end_time <= ts_w;
                overflow_count  <= '0;
                phase           <= duty_enable ? PH_FALL : PH_START;
              end
            end
            PH_FALL: begin
              if (edge_falling) begin
                phase          <= PH_START;
                overflow_count <= '0;
              end
            end
            default: begin
              if (!edge_falling) begin
                start_time     <= ts_w;
                phase          <= PH_PERIOD;
                overflow_count <= '0;
              end
            end
          endcase
        end
      end
    end
  end

  // Pending result and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (operation == OP_OVERFLOW) begin
        pend_period  <= '0;
        duty_q       <= '0;
        pend_timeout <= 1'b1;
      end else begin
        pend_period  <= period_m;
        duty_q       <= duty_now;
        pend_timeout <= 1'b0;
      end
      rem <= on_m;
    end else if (cmd.div_step) begin
      rem    <= rem_next;
      duty_q <= {duty_q[DUTY_W-2:0], q_bit};
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      period_ticks  <= PERIOD_W'(pend_period);
      duty_fraction <= duty_q;
      timed_out     <= pend_timeout;
    end
  end

  // A timeout word carries no measurement
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> period_ticks == '0 && duty_fraction == '0)
    else $error("timeout word with nonzero measurement");

  // Phase returns to start after any result is taken in
  a_emit_rearm: assert property (@(posedge clk) disable iff (rst)
    cmd.load && st.emits |=> phase == PH_START && overflow_count == '0)
    else $error("block did not rearm after a result");

endmodule

### rtl/period_duty_capture_meter.sv
// Period and duty capture meter.
// Input channel (in_valid/in_ready): one word per capture edge or timer
// overflow tick. Output channel (out_valid/out_ready): one word per finished
// measurement or timeout abort, held in an output register.
// Config port: cfg_we writes cfg_data into register cfg_index at the edge;
// write only while the block is idle.
// Timing: a word that completes no measurement is taken at once and leaves
// the block idle, so the next word can follow at once. A result without
// division (timeout, duty off, zero period, saturated duty) is loaded into
// the pending stage at accept and pushed from there into the output register;
// a duty result first passes the restoring divider, which makes one quotient
// bit per cycle. in_ready is low from the accept of a result-producing word
// until that result enters the output register.
// Stall: a held output word keeps in_ready high; a second result then waits
// in the pending stage with in_ready low until out_ready frees the register.
// Reset: rst clears the phase, the overflow count and the output valid, and
// loads duty on, wide timestamps and an overflow limit of one.
module period_duty_capture_meter
  import pdcm_pkg::*;
#(
  parameter int TIMESTAMP_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic                  edge_falling,
  input  logic [TS_W-1:0]       timestamp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PERIOD_W-1:0]   period_ticks,
  output logic [DUTY_W-1:0]     duty_fraction,
  output logic                  timed_out
);

  cmd_t    cmd;
  status_t st;

  pdcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pdcm_datapath #(
    .TIMESTAMP_BITS (TIMESTAMP_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .edge_falling  (edge_falling),
    .timestamp     (timestamp),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .period_ticks  (period_ticks),
    .duty_fraction (duty_fraction),
    .timed_out     (timed_out)
  );

endmodule

### bench/tb_period_duty_capture_meter.sv
module tb_period_duty_capture_meter;
  timeunit 1ns;
  timeprecision 1ps;

  import pdcm_pkg::*;

  localparam logic EDGE_RISE = 1'b0;
  localparam logic EDGE_FALL = 1'b1;

  localparam int IDLE_PCT        = 6;
  localparam int CALM_FROM       = 500;
  localparam int CALM_TO         = 800;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RAND_PHASES     = 10;
  localparam int WORDS_PER_PHASE = 140;
  localparam int CYCLE_LIMIT     = 500000;

  // One measurement word as it leaves the block
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [DUTY_W-1:0]   duty;
    logic                tmo;
  } meas_t;

  typedef enum logic {
    ROW_WORD,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic                  op;
    logic                  fall;
    logic [TS_W-1:0]       ts;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  typed;
    meas_t                 want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_CAPTURE;
  logic edge_falling = EDGE_RISE;
  logic [TS_W-1:0] timestamp = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PERIOD_W-1:0] period_ticks;
  logic [DUTY_W-1:0] duty_fraction;
  logic timed_out;

  // Mirror of the block's registers and measurement state
  logic duty_on = 1'b1;
  logic wide_on = 1'b1;
  logic [LIMIT_W-1:0] ovf_limit = 2'd1;
  phase_t ph = PH_START;
  logic [TS_W-1:0] t_start = '0;
  logic [TS_W-1:0] t_period_end = '0;
  int ovf_count = 0;

  meas_t pending_meas[$];
  plan_row_t plan_rows[$];
  int errors = 0;
  int words_sent = 0;
  int cycle_count = 0;
  logic calm = 1'b0;

  period_duty_capture_meter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .edge_falling (edge_falling),
    .timestamp    (timestamp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .period_ticks (period_ticks),
    .duty_fraction(duty_fraction),
    .timed_out    (timed_out)
  );

  always #10 clk = ~clk;

  // Run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stalls, none during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  // Finished measurement: period modulo the active width, duty in 1/256
  function automatic meas_t close_measurement(input logic [TS_W-1:0] on_end);
    logic [TS_W-1:0] mask, span, on_span;
    logic [31:0] q;
    meas_t res;
    mask = wide_on ? 24'hFFFFFF : 24'h00FFFF;
    span = (t_period_end - t_start) & mask;
    on_span = (on_end - t_period_end) & mask;
    q = '0;
    if (duty_on && span != '0) q = {on_span, 8'h00} / {8'h00, span};
    if (q > 32'd255) q = 32'd255;
    res.period = span;
    res.duty = q[DUTY_W-1:0];
    res.tmo = 1'b0;
    ph = PH_START;
    ovf_count = 0;
    return res;
  endfunction

  // Advance the mirrored state by one word; returns 1 when a word comes out
  function automatic logic predict_measurement(input logic op, input logic fall,
                                               input logic [TS_W-1:0] ts,
                                               output meas_t res);
    res = '0;
    if (op == OP_OVERFLOW) begin
      if (ovf_count + 1 > int'(ovf_limit)) begin
        res.tmo = 1'b1;
        ph = PH_START;
        ovf_count = 0;
        return 1'b1;
      end
      ovf_count++;
      return 1'b0;
    end
    case (ph)
      PH_PERIOD: begin
        if (fall == EDGE_FALL) return 1'b0;
        t_period_end = ts;
        if (duty_on) begin
          ph = PH_FALL;
          ovf_count = 0;
          return 1'b0;
        end
        res = close_measurement(ts);
        return 1'b1;
      end
      PH_FALL: begin
        if (fall == EDGE_RISE) return 1'b0;
        res = close_measurement(ts);
        return 1'b1;
      end
      default: begin
        if (fall == EDGE_FALL) return 1'b0;
        t_start = ts;
        ph = PH_PERIOD;
        ovf_count = 0;
        return 1'b0;
      end
    endcase
  endfunction

  // Queue the expectation, then hold the word until it is taken
  task automatic send_word(input logic op, input logic fall, input logic [TS_W-1:0] ts,
                           input logic typed, input meas_t want);
    meas_t guess;
    logic hit, rdy;
    hit = predict_measurement(op, fall, ts, guess);
    if (typed) begin
      hit = 1'b1;
      guess = want;
    end
    if (hit) pending_meas.push_back(guess);
    calm = (words_sent >= CALM_FROM && words_sent < CALM_TO);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    edge_falling <= fall;
    timestamp <= ts;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    words_sent++;
  endtask

  // Wait for every expected word, then let the block go quiet
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_DUTY_ENABLE:     duty_on = val[0];
      CFG_WIDE_TIMESTAMPS: wide_on = val[0];
      CFG_OVERFLOW_LIMIT:  ovf_limit = val[LIMIT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void plan_word(input logic op, input logic fall,
                                    input logic [TS_W-1:0] ts);
    plan_row_t row;
    row = '{kind: ROW_WORD, op: op, fall: fall, ts: ts, idx: '0, val: '0,
            typed: 1'b0, want: '0};
    plan_rows.push_back(row);
  endfunction

  function automatic void plan_checked(input logic op, input logic fall,
                                       input logic [TS_W-1:0] ts,
                                       input logic [PERIOD_W-1:0] p,
                                       input logic [DUTY_W-1:0] d, input logic t);
    plan_row_t row;
    row = '{kind: ROW_WORD, op: op, fall: fall, ts: ts, idx: '0, val: '0,
            typed: 1'b1, want: meas_t'{p, d, t}};
    plan_rows.push_back(row);
  endfunction

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{kind: ROW_WRITE, op: OP_CAPTURE, fall: EDGE_RISE, ts: '0, idx: idx,
            val: val, typed: 1'b0, want: '0};
    plan_rows.push_back(row);
  endfunction

  // Compare each taken output word with the oldest expectation
  always @(negedge clk) begin
    meas_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_meas.size() == 0) begin
        report_mismatch("word with nothing expected", 32'(period_ticks), '0);
      end else begin
        want = pending_meas.pop_front();
        if (period_ticks !== want.period)
          report_mismatch("period_ticks", 32'(period_ticks), 32'(want.period));
        if (duty_fraction !== want.duty)
          report_mismatch("duty_fraction", 32'(duty_fraction), 32'(want.duty));
        if (timed_out !== want.tmo)
          report_mismatch("timed_out", 32'(timed_out), 32'(want.tmo));
      end
    end
  end

  initial begin
    plan_row_t row;
    logic [TS_W-1:0] ts, span;
    logic op, fall, de, wt;
    logic [LIMIT_W-1:0] lim;
    int r;

    // Directed: reset defaults are duty on, wide, limit one
    plan_word(OP_OVERFLOW, EDGE_RISE, 24'h000000);
    plan_checked(OP_OVERFLOW, EDGE_RISE, 24'h000000, 24'd0, 8'd0, 1'b1);
    plan_word(OP_CAPTURE, EDGE_FALL, 24'hFFFFFF);        // falling while idle
    plan_word(OP_CAPTURE, EDGE_RISE, 24'h000000);
    plan_word(OP_CAPTURE, EDGE_RISE, 24'd1000);
    plan_word(OP_CAPTURE, EDGE_RISE, 24'd5);             // rising while on-time
    plan_checked(OP_CAPTURE, EDGE_FALL, 24'd1500, 24'd1000, 8'd128, 1'b0);
    // wrap across the top of the counter, duty saturates
    plan_word(OP_CAPTURE, EDGE_RISE, 24'hFFFFFF);
    plan_word(OP_CAPTURE, EDGE_RISE, 24'h00000F);
    plan_checked(OP_CAPTURE, EDGE_FALL, 24'hFFFFFF, 24'd16, 8'd255, 1'b0);
    // zero period
    plan_word(OP_CAPTURE, EDGE_RISE, 24'd5);
    plan_word(OP_CAPTURE, EDGE_RISE, 24'd5);
    plan_checked(OP_CAPTURE, EDGE_FALL, 24'd100, 24'd0, 8'd0, 1'b0);
    // narrow timestamps drop the top byte
    plan_write(CFG_WIDE_TIMESTAMPS, 2'd0);
    plan_word(OP_CAPTURE, EDGE_RISE, 24'hAB0000);
    plan_word(OP_CAPTURE, EDGE_RISE, 24'h120010);
    plan_checked(OP_CAPTURE, EDGE_FALL, 24'h340018, 24'd16, 8'd128, 1'b0);
    // duty off: done at the second rising edge
    plan_write(CFG_DUTY_ENABLE, 2'd0);
    plan_word(OP_CAPTURE, EDGE_RISE, 24'h000000);
    plan_checked(OP_CAPTURE, EDGE_RISE, 24'h00FFFF, 24'h00FFFF, 8'd0, 1'b0);
    // limit zero aborts on the first tick
    plan_write(CFG_OVERFLOW_LIMIT, 2'd0);
    plan_checked(OP_OVERFLOW, EDGE_FALL, 24'hFFFFFF, 24'd0, 8'd0, 1'b1);
    // limit three, run ticks past it
    plan_write(CFG_OVERFLOW_LIMIT, 2'd3);
    plan_write(CFG_DUTY_ENABLE, 2'd1);
    plan_write(CFG_WIDE_TIMESTAMPS, 2'd1);
    plan_word(OP_CAPTURE, EDGE_RISE, 24'd1);
    plan_word(OP_CAPTURE, EDGE_FALL, 24'd2);             // falling while on period
    repeat (4) plan_word(OP_OVERFLOW, EDGE_RISE, 24'd0);
    // duty switched off while waiting for the falling edge
    plan_word(OP_CAPTURE, EDGE_RISE, 24'd10);
    plan_word(OP_CAPTURE, EDGE_RISE, 24'd110);
    plan_write(CFG_DUTY_ENABLE, 2'd0);
    plan_checked(OP_CAPTURE, EDGE_FALL, 24'd160, 24'd100, 8'd0, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_rows[i]) begin
      row = plan_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.idx, row.val);
      end else begin
        send_word(row.op, row.fall, row.ts, row.typed, row.want);
      end
    end

    // Random: mostly well-formed measurements with ticks and stray edges mixed in
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin de = 1'b0; wt = 1'b0; lim = 2'd0; end
        1: begin de = 1'b1; wt = 1'b1; lim = 2'd3; end
        2: begin de = 1'b1; wt = 1'b0; lim = 2'd1; end
        default: begin
          de = 1'($urandom_range(0, 1));
          wt = 1'($urandom_range(0, 1));
          lim = 2'($urandom_range(0, 3));
        end
      endcase
      write_reg(CFG_DUTY_ENABLE, {1'b0, de});
      write_reg(CFG_WIDE_TIMESTAMPS, {1'b0, wt});
      write_reg(CFG_OVERFLOW_LIMIT, lim);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        ts = 24'($urandom());
        fall = 1'($urandom_range(0, 1));
        op = OP_CAPTURE;
        if (r < 10) begin
          op = OP_OVERFLOW;
        end else if (r < 20) begin
          fall = (ph == PH_FALL) ? EDGE_RISE : EDGE_FALL;
        end else begin
          fall = (ph == PH_FALL) ? EDGE_FALL : EDGE_RISE;
          if (ph == PH_PERIOD && $urandom_range(0, 7) != 0) begin
            ts = t_start + (($urandom_range(0, 7) == 0) ? 24'd0
                                                         : 24'($urandom_range(1, 5000)));
          end else if (ph == PH_FALL && $urandom_range(0, 7) != 0) begin
            span = (t_period_end - t_start) & (wide_on ? 24'hFFFFFF : 24'h00FFFF);
            ts = t_period_end
                 + 24'((longint'($urandom_range(0, 280)) * longint'(span)) >> 8);
          end
        end
        send_word(op, fall, ts, 1'b0, '0);
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pdcm_pkg.sv
rtl/pdcm_ctrl.sv
rtl/pdcm_datapath.sv
rtl/period_duty_capture_meter.sv
bench/tb_period_duty_capture_meter.sv
